// ===== rtl/core/fcte_pkg.sv =====
// ============================================================================
// fcte_pkg: shared types and constants of the cluster table engine
// Holds the request and result formats, operation and class codes, register
// indexes, the controller/datapath interface and the entry classifier.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fcte_pkg;

  typedef logic [2:0]  func_t;
  typedef logic [2:0]  class_t;
  typedef logic [2:0]  cfg_idx_t;
  typedef logic [27:0] entry_t;

  localparam func_t FUNC_READ  = 3'd0;
  localparam func_t FUNC_WRITE = 3'd1;
  localparam func_t FUNC_TEST  = 3'd2;
  localparam func_t FUNC_FIND  = 3'd3;
  localparam func_t FUNC_CHAIN = 3'd4;
  localparam func_t FUNC_MAP   = 3'd5;

  localparam class_t CLASS_FREE     = 3'd0;
  localparam class_t CLASS_LINK     = 3'd1;
  localparam class_t CLASS_END      = 3'd2;
  localparam class_t CLASS_BAD      = 3'd3;
  localparam class_t CLASS_RESERVED = 3'd4;

  localparam cfg_idx_t CFG_RESERVED_SECTORS = 3'd0;
  localparam cfg_idx_t CFG_FAT_COPIES       = 3'd1;
  localparam cfg_idx_t CFG_FAT_SECTORS      = 3'd2;
  localparam cfg_idx_t CFG_SECTORS_PER_CL   = 3'd3;
  localparam cfg_idx_t CFG_PARTITION_START  = 3'd4;
  localparam cfg_idx_t CFG_CLUSTER_LIMIT    = 3'd5;

  localparam entry_t ENTRY_END_MIN  = 28'hFFFFFF8;
  localparam entry_t ENTRY_BAD      = 28'hFFFFFF7;
  localparam entry_t ENTRY_RSVD_MIN = 28'hFFFFFF0;
  localparam entry_t ENTRY_FREE     = 28'h0000000;

  typedef struct packed {
    func_t  func;
    entry_t cluster;
    entry_t entry_value;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    class_t      entry_class;
    logic        is_free;
    logic        error;
  } res_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic look;
    logic check;
    logic map1;
    logic map2;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic look_done;
    logic check_done;
    logic is_map;
  } sts_t;

  function automatic class_t classify(input entry_t e);
    class_t c;
    begin
      c = CLASS_LINK;
      if (e == ENTRY_FREE) c = CLASS_FREE;
      else if (e >= ENTRY_END_MIN) c = CLASS_END;
      else if (e == ENTRY_BAD) c = CLASS_BAD;
      else if (e >= ENTRY_RSVD_MIN) c = CLASS_RESERVED;
      return c;
    end
  endfunction

  function automatic entry_t next_of(input entry_t e);
    return (classify(e) == CLASS_LINK) ? e : ENTRY_FREE;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fcte_ctrl.sv =====
// ============================================================================
// fcte_ctrl: sequencing state machine
// Steps the datapath through table clearing, operation look and check phases,
// the sector mapping stages and the result strobe.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fcte_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               done_o,
  output fcte_pkg::cmd_t     cmd_o,
  input  wire fcte_pkg::sts_t sts_i
);
  import fcte_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_LOOK  = 7'b0000100,
    ST_CHECK = 7'b0001000,
    ST_MAP1  = 7'b0010000,
    ST_MAP2  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clear_last) state_d = ST_IDLE;
      ST_IDLE:  if (start) state_d = ST_LOOK;
      ST_LOOK: begin
        if (sts_i.is_map) state_d = ST_MAP1;
        else if (sts_i.look_done) state_d = ST_DONE;
        else state_d = ST_CHECK;
      end
      ST_CHECK: state_d = sts_i.check_done ? ST_DONE : ST_LOOK;
      ST_MAP1:  state_d = ST_MAP2;
      ST_MAP2:  state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.clear  = (state_q == ST_CLEAR);
    cmd_o.accept = (state_q == ST_IDLE) && start;
    cmd_o.look   = (state_q == ST_LOOK);
    cmd_o.check  = (state_q == ST_CHECK);
    cmd_o.map1   = (state_q == ST_MAP1);
    cmd_o.map2   = (state_q == ST_MAP2);
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

`default_nettype wire

// ===== rtl/core/fcte_datapath.sv =====
// ============================================================================
// fcte_datapath: cluster table, registers and result logic
// Holds the cluster table memory, the volume geometry registers, the walk
// cursor and counter, the sector mapping arithmetic and the result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fcte_datapath #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fcte_pkg::cmd_t     cmd_i,
  output fcte_pkg::sts_t          sts_o,
  input  wire fcte_pkg::req_t     req_i,
  output fcte_pkg::res_t          res_o,
  input  wire logic               cfg_we_i,
  input  wire fcte_pkg::cfg_idx_t cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  import fcte_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = AW + 1;
  localparam entry_t       NumEntries = 28'(TABLE_ENTRIES);
  localparam logic [CW-1:0] NumCount  = CW'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LastAddr  = AW'(TABLE_ENTRIES - 1);

  // Table storage; its contents are established by the clearing sweep.
  entry_t mem_q [TABLE_ENTRIES];
  entry_t rdata_q;

  logic [15:0] rsv_sec_q;
  logic [2:0]  copies_q;
  logic [31:0] fat_sec_q;
  logic [7:0]  spc_q;
  logic [31:0] pstart_q;
  logic [28:0] limit_q;

  req_t          op_q;
  entry_t        cur_q, cur_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] clr_q;
  logic [31:0]   acc_a_q, acc_b_q;
  res_t          res_q, res_d;

  logic          in_range;
  logic          look_done;
  logic          check_done;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  class_t        rd_class;

  assign in_range = (cur_q < NumEntries);
  assign rd_class = classify(rdata_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_sec_q <= 16'd32;
      copies_q  <= 3'd2;
      fat_sec_q <= 32'd32;
      spc_q     <= 8'd8;
      pstart_q  <= 32'd0;
      limit_q   <= 29'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RESERVED_SECTORS: rsv_sec_q <= cfg_data_i[15:0];
        CFG_FAT_COPIES:       copies_q  <= cfg_data_i[2:0];
        CFG_FAT_SECTORS:      fat_sec_q <= cfg_data_i;
        CFG_SECTORS_PER_CL:   spc_q     <= cfg_data_i[7:0];
        CFG_PARTITION_START:  pstart_q  <= cfg_data_i;
        CFG_CLUSTER_LIMIT:    limit_q   <= cfg_data_i[28:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q[AW-1:0];
    mem_wdata = op_q.entry_value;
    if (cmd_i.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = ENTRY_FREE;
    end else if (cmd_i.look && (op_q.func == FUNC_WRITE) && in_range) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[cur_q[AW-1:0]];
  end

  always_comb begin
    look_done = 1'b1;
    res_d     = res_q;
    unique case (op_q.func)
      FUNC_READ, FUNC_TEST, FUNC_WRITE: begin
        look_done = !in_range || (op_q.func == FUNC_WRITE);
        res_d.error = !in_range;
      end
      FUNC_FIND: begin
        look_done = ({1'b0, cur_q} >= limit_q) || !in_range;
      end
      FUNC_CHAIN: begin
        look_done   = (cur_q == ENTRY_FREE) || (cnt_q == NumCount) || !in_range;
        res_d.value = 32'(cnt_q);
        res_d.error = (cur_q != ENTRY_FREE) && ((cnt_q == NumCount) || !in_range);
      end
      FUNC_MAP: look_done = 1'b0;
      default:  look_done = 1'b1;
    endcase
  end

  always_comb begin
    check_done = 1'b1;
    cur_d      = cur_q;
    cnt_d      = cnt_q;
    unique case (op_q.func)
      FUNC_FIND: begin
        check_done = (rdata_q == ENTRY_FREE);
        cur_d      = cur_q + 28'd1;
      end
      FUNC_CHAIN: begin
        check_done = 1'b0;
        cur_d      = next_of(rdata_q);
        cnt_d      = cnt_q + 1'b1;
      end
      default: check_done = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= req_i;
      cur_q <= (req_i.func == FUNC_FIND) ? 28'd2 : req_i.cluster;
      cnt_q <= '0;
      res_q <= '0;
    end else if (cmd_i.look) begin
      acc_a_q <= 32'(copies_q * fat_sec_q);
      acc_b_q <= 32'((32'(cur_q) - 32'd2) * spc_q);
      if (look_done && (op_q.func != FUNC_MAP)) begin
        res_q <= res_d;
      end
    end else if (cmd_i.check) begin
      cur_q <= cur_d;
      cnt_q <= cnt_d;
      unique case (op_q.func)
        FUNC_READ: begin
          res_q.entry_class <= rd_class;
          res_q.value       <= (rd_class == CLASS_LINK) ? 32'(rdata_q) : 32'd0;
          res_q.is_free     <= (rd_class == CLASS_FREE);
        end
        FUNC_TEST: res_q.is_free <= (rdata_q == ENTRY_FREE);
        FUNC_FIND: if (check_done) res_q.value <= 32'(cur_q);
        default: ;
      endcase
    end else if (cmd_i.map1) begin
      acc_a_q <= 32'(rsv_sec_q) + acc_a_q;
      acc_b_q <= acc_b_q + pstart_q;
    end else if (cmd_i.map2) begin
      res_q.value <= acc_a_q + acc_b_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clear_last = (clr_q == LastAddr);
    sts_o.look_done  = look_done;
    sts_o.check_done = check_done;
    sts_o.is_map     = (op_q.func == FUNC_MAP);
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/fat_cluster_table_engine_unit.sv =====
// ============================================================================
// fat_cluster_table_engine_unit: FAT32 cluster table engine
// Holds a cluster allocation table and performs table and mapping commands.
// ============================================================================
// A command is taken at a clock edge where start is high and busy is low; busy
// stays high until its result has been shown. Each command gives one result,
// present on res_o for the single cycle in which done_o is high; the receiver
// must take it then, as it cannot hold results off.
// Steps of the sequencer after the accepting edge, up to the result strobe:
//   write: look, strobe; read and test free: look, check, strobe;
//   sector mapping: look, map1, map2, strobe (multiply, two add stages);
//   find free: look and check per entry examined, strobe after the check
//   that finds a free entry, or after a look at the limit or table end;
//   chain count: look and check per link followed, then look and strobe.
// The table memory has one read and one write port and is read once per step.
// A new command can be taken in the cycle after the strobe; none is taken
// while a command is in progress.
// After reset the table is swept to free, one entry per cycle, with busy high.
// Geometry registers return to their defaults at reset.
// The configuration channel is always ready; a transfer with an index beyond
// the register list is ignored. Write registers only while the engine is idle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fat_cluster_table_engine_unit #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire fcte_pkg::req_t     req_i,
  output logic                    done_o,
  output fcte_pkg::res_t          res_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire fcte_pkg::cfg_idx_t cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  import fcte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  fcte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  fcte_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .res_o       (res_o),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire
